// File: design/id3pe_pkg.sv
// ----------------------------------------------------------------------------
// id3pe_pkg
// Shared types and constants of the ID3v2 picture extractor.
// ----------------------------------------------------------------------------
package id3pe_pkg;

    localparam int TAG_W     = 28;
    localparam int SIZE_BITS = 28;

    localparam logic [TAG_W-1:0] MAX_TAG_RESET = 28'd33554432;

    localparam logic [2:0] ST_PICTURE   = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_NO_PIC    = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic [7:0]  ID3_I      = 8'h49;
    localparam logic [7:0]  ID3_D      = 8'h44;
    localparam logic [7:0]  ID3_3      = 8'h33;
    localparam logic [7:0]  VER_V3     = 8'h03;
    localparam logic [7:0]  VER_V4     = 8'h04;
    localparam int          EXT_FLAG_BIT = 6;
    localparam logic [31:0] APIC_ID    = 32'h41504943;
    localparam logic [7:0]  ENC_UTF16  = 8'h01;
    localparam logic [7:0]  ENC_UTF16BE = 8'h02;
    localparam logic [31:0] FRAME_HDR_BYTES = 32'd10;
    localparam logic [31:0] MIN_APIC_BYTES  = 32'd5;
    localparam logic [31:0] EXT_SIZE_BYTES  = 32'd4;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_EXT,
        PH_SKIP,
        PH_FHDR,
        PH_ENC,
        PH_MIME,
        PH_TYPE,
        PH_DESC,
        PH_IMG,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       is_last;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_res;

endpackage

// File: design/id3pe_in_reg.sv
// ----------------------------------------------------------------------------
// id3pe_in_reg
// Input register: holds one file byte until the parser takes it.
// ----------------------------------------------------------------------------
module id3pe_in_reg
    import id3pe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

endmodule

// File: design/id3pe_parser.sv
// ----------------------------------------------------------------------------
// id3pe_parser
// Tag walker: header check, extended header and frame skipping, APIC field
// parsing. Takes one byte per valid cycle, at most one result per byte.
// ----------------------------------------------------------------------------
module id3pe_parser
    import id3pe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_item         i_item,
    input  logic [TAG_W-1:0] i_max_tag,
    output t_step_res        o_res
);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_ver, n_ver;
    logic             r_ext, n_ext;
    logic [TAG_W-1:0] r_tl, n_tl;
    logic [TAG_W-1:0] r_tp, n_tp;
    logic [TAG_W-1:0] r_skip, n_skip;
    logic [31:0]      r_ident, n_ident;
    logic [31:0]      r_fl, n_fl;
    logic [TAG_W-1:0] r_fp, n_fp;
    logic             r_wide, n_wide;
    logic [1:0]       r_pair, n_pair;

    logic [7:0]  b;
    logic        eof;
    logic [31:0] fl_acc;
    logic [32:0] ext_off;
    logic        apic_last;
    logic        hdr_bad;
    logic        d_fail;
    logic [2:0]  d_fail_st;
    logic        d_arrive;
    logic        d_img;
    logic        d_term;
    t_phase      d_goto;
    logic        arrive_fail;
    logic        fin;
    logic        trunc;

    assign b   = i_item.byte_in;
    assign eof = i_item.end_of_file;

    // Per-byte decode: data updates and the decisions this byte makes
    always_comb begin
        n_cnt     = r_cnt;
        n_ver     = r_ver;
        n_ext     = r_ext;
        n_tl      = r_tl;
        n_tp      = r_tp;
        n_skip    = r_skip;
        n_ident   = r_ident;
        n_fl      = r_fl;
        n_fp      = r_fp;
        n_wide    = r_wide;
        n_pair    = r_pair;
        ext_off   = '0;
        d_fail    = 1'b0;
        d_fail_st = ST_BAD_HDR;
        d_arrive  = 1'b0;
        d_img     = 1'b0;
        d_term    = 1'b0;
        d_goto    = r_phase;

        fl_acc    = r_ver ? {r_fl[24:0], b[6:0]} : {r_fl[23:0], b};
        apic_last = (33'(r_fp) + 33'd1) >= 33'(r_fl);
        hdr_bad   = (r_cnt == 4'd0 && b != ID3_I) || (r_cnt == 4'd1 && b != ID3_D) ||
                    (r_cnt == 4'd2 && b != ID3_3) ||
                    (r_cnt == 4'd3 && b != VER_V3 && b != VER_V4);

        unique case (r_phase)
            PH_HDR: begin
                n_cnt = r_cnt + 4'd1;
                if (hdr_bad) begin
                    d_fail = 1'b1;
                end else begin
                    if (r_cnt == 4'd3) n_ver = (b == VER_V4);
                    if (r_cnt == 4'd5) n_ext = b[EXT_FLAG_BIT];
                    if (r_cnt >= 4'd6) n_tl = {r_tl[TAG_W-8:0], b[6:0]};
                    if (r_cnt >= 4'd9) begin
                        if (n_tl == '0 || n_tl > i_max_tag ||
                            (32'(n_tl) >> SIZE_BITS) != 32'd0) begin
                            d_fail = 1'b1;
                        end else if (32'(n_tl) < FRAME_HDR_BYTES) begin
                            d_fail    = 1'b1;
                            d_fail_st = ST_NO_PIC;
                        end else if (r_ext) begin
                            d_goto = PH_EXT;
                            n_cnt  = '0;
                            n_fl   = '0;
                        end else begin
                            n_tp     = '0;
                            d_arrive = 1'b1;
                        end
                    end
                end
            end
            PH_EXT: begin
                n_cnt = r_cnt + 4'd1;
                n_tp  = r_tp + 1'b1;
                n_fl  = fl_acc;
                if (r_cnt >= 4'd3) begin
                    // v2.3 size excludes its own four bytes; never rewind
                    ext_off = r_ver ? {1'b0, fl_acc}
                                    : {1'b0, fl_acc} + 33'(EXT_SIZE_BYTES);
                    if (ext_off < 33'(n_tp)) ext_off = 33'(n_tp);
                    if (34'(ext_off) + 34'(FRAME_HDR_BYTES) > 34'(r_tl)) begin
                        d_fail    = 1'b1;
                        d_fail_st = ST_NO_PIC;
                    end else begin
                        n_skip = ext_off[TAG_W-1:0];
                        if (n_skip == n_tp) d_arrive = 1'b1;
                        else d_goto = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_tp = r_tp + 1'b1;
                if (n_tp >= r_skip) d_arrive = 1'b1;
            end
            PH_FHDR: begin
                n_cnt = r_cnt + 4'd1;
                n_tp  = r_tp + 1'b1;
                if (r_cnt < 4'd4) begin
                    n_ident = {r_ident[23:0], b};
                    if (r_cnt == 4'd3 && n_ident == '0) begin
                        d_fail    = 1'b1;
                        d_fail_st = ST_NO_PIC;
                    end
                end else if (r_cnt < 4'd8) begin
                    n_fl = fl_acc;
                    if (r_cnt == 4'd7) begin
                        if (fl_acc == '0 ||
                            34'(n_tp) + 34'd2 + 34'(fl_acc) > 34'(r_tl)) begin
                            d_fail    = 1'b1;
                            d_fail_st = ST_NO_PIC;
                        end else if (r_ident == APIC_ID && fl_acc < MIN_APIC_BYTES) begin
                            d_fail    = 1'b1;
                            d_fail_st = ST_MALFORMED;
                        end
                    end
                end else if (r_cnt >= 4'd9) begin
                    if (r_ident == APIC_ID) begin
                        d_goto = PH_ENC;
                        n_fp   = '0;
                    end else begin
                        n_skip = n_tp + r_fl[TAG_W-1:0];
                        d_goto = PH_SKIP;
                    end
                end
            end
            PH_ENC: begin
                n_tp   = r_tp + 1'b1;
                n_fp   = r_fp + 1'b1;
                n_wide = (b == ENC_UTF16) || (b == ENC_UTF16BE);
                if (apic_last) begin
                    d_fail    = 1'b1;
                    d_fail_st = ST_MALFORMED;
                end else begin
                    d_goto = PH_MIME;
                end
            end
            PH_MIME: begin
                n_tp = r_tp + 1'b1;
                n_fp = r_fp + 1'b1;
                if (apic_last) begin
                    d_fail    = 1'b1;
                    d_fail_st = ST_MALFORMED;
                end else if (b == 8'h00) begin
                    d_goto = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_tp = r_tp + 1'b1;
                n_fp = r_fp + 1'b1;
                if (apic_last) begin
                    d_fail    = 1'b1;
                    d_fail_st = ST_MALFORMED;
                end else begin
                    d_goto = PH_DESC;
                    n_pair = '0;
                end
            end
            PH_DESC: begin
                n_tp = r_tp + 1'b1;
                n_fp = r_fp + 1'b1;
                // UTF-16 ends on a null pair aligned to the pair boundary
                if (!r_wide) begin
                    d_term = (b == 8'h00);
                end else if (!r_pair[0]) begin
                    n_pair = {b == 8'h00, 1'b1};
                end else begin
                    d_term = r_pair[1] && (b == 8'h00);
                    n_pair = '0;
                end
                if (apic_last) d_arrive = 1'b1;
                else if (d_term) d_goto = PH_IMG;
            end
            PH_IMG: begin
                n_tp  = r_tp + 1'b1;
                n_fp  = r_fp + 1'b1;
                d_img = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (d_arrive) begin
            n_cnt   = '0;
            n_ident = '0;
            n_fl    = '0;
        end
        arrive_fail = (29'(n_tp) + 29'(FRAME_HDR_BYTES)) > 29'(n_tl);
    end

    assign fin   = d_fail || (d_arrive && arrive_fail) || (d_img && apic_last);
    assign trunc = eof && !fin && (r_phase != PH_DONE);

    // Next state
    always_comb begin
        if (fin) n_phase = PH_DONE;
        else if (d_arrive) n_phase = PH_FHDR;
        else n_phase = d_goto;
    end

    // Result
    always_comb begin
        o_res.valid         = i_valid && (trunc || fin || d_img);
        o_res.item.byte_out = 8'h00;
        o_res.item.is_last  = 1'b1;
        o_res.item.status   = ST_NO_PIC;
        if (trunc) begin
            o_res.item.status = ST_TRUNC;
        end else if (d_fail) begin
            o_res.item.status = d_fail_st;
        end else if (d_img) begin
            o_res.item.status   = ST_PICTURE;
            o_res.item.byte_out = b;
            o_res.item.is_last  = apic_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && eof)) begin
            r_phase <= PH_HDR;
            r_cnt   <= '0;
            r_ver   <= 1'b0;
            r_ext   <= 1'b0;
            r_tl    <= '0;
            r_tp    <= '0;
            r_skip  <= '0;
            r_ident <= '0;
            r_fl    <= '0;
            r_fp    <= '0;
            r_wide  <= 1'b0;
            r_pair  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ver   <= n_ver;
            r_ext   <= n_ext;
            r_tl    <= n_tl;
            r_tp    <= n_tp;
            r_skip  <= n_skip;
            r_ident <= n_ident;
            r_fl    <= n_fl;
            r_fp    <= n_fp;
            r_wide  <= n_wide;
            r_pair  <= n_pair;
        end
    end

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && i_valid && !eof) |-> !o_res.valid)
        else $error("result produced after the final result of a file");

    a_pos_in_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HDR && r_phase != PH_DONE) |-> (r_tp <= r_tl))
        else $error("tag position ran past the tag length");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_cnt <= 4'd9))
        else $error("header byte count ran past the header");

endmodule

// File: design/id3pe_out_reg.sv
// ----------------------------------------------------------------------------
// id3pe_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module id3pe_out_reg
    import id3pe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_step_res i_res,
    input  logic      i_out_ready,
    output logic      o_space,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_item <= i_res.item;
        end
    end

endmodule

// File: design/id3v2_picture_extractor.sv
// ----------------------------------------------------------------------------
// id3v2_picture_extractor
// Pulls the first APIC picture out of the ID3v2.3/2.4 tag of an MP3 stream.
// ----------------------------------------------------------------------------
// Feed the file one byte per item, with end_of_file set on the final byte;
// the block then restarts for the next file. One byte is accepted every
// cycle while the result side keeps up; each result passes through the input
// register, one pass of parser logic and the result register, and a result
// that waits on the sink holds the input back. Picture bytes come out with
// status 0 and is_last on the final one; any failure instead gives a single
// status item (byte 0, is_last 1), after which bytes up to end_of_file give
// nothing. The user must write max_tag_bytes through i_cfg_we/i_cfg_wdata
// only while the block is idle; the block does not enforce it. It resets to 32 MiB.
module id3v2_picture_extractor
    import id3pe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [TAG_W-1:0] i_cfg_wdata
);

    logic [TAG_W-1:0] r_max_tag;
    logic             in_valid;
    t_in_item         in_item;
    logic             space;
    logic             advance;
    t_step_res        res;

    assign advance = in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tag <= MAX_TAG_RESET;
        end else if (i_cfg_we) begin
            r_max_tag <= i_cfg_wdata;
        end
    end

    id3pe_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_take     (advance),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    id3pe_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (advance),
        .i_item    (in_item),
        .i_max_tag (r_max_tag),
        .o_res     (res)
    );

    id3pe_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_PICTURE) |->
            (o_out_item.is_last && o_out_item.byte_out == 8'h00))
        else $error("status item without is_last or with nonzero byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= ST_TRUNC))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed or dropped while waiting");

endmodule
